/* hdl/fbdtm_pkg.sv */
// Shared types and constants of the dirty tile map.
package fbdtm_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TILE_W   = 6;
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned CFG_IDX_W = 2;
  // Tiles per axis after rounding up: at most 2050 / 4 = 512.
  localparam int unsigned TCNT_W   = 10;
  // Tile coordinate after dividing a pixel coordinate: at most 1023 / 4.
  localparam int unsigned TPOS_W   = 8;
  // Shift of the reciprocal used for the divide by tile size.
  localparam int unsigned RECIP_SH = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_COMPARE = 3'd0,
    MODE_FORCE   = 3'd1,
    MODE_CLEAN   = 3'd2,
    MODE_QUERY   = 3'd3,
    MODE_RESET   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_CMP_DIS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_RD,
    ST_WR
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [WORD_W-1:0]  pixel_value;
    logic [TILE_W-1:0]  tile_x;
    logic [TILE_W-1:0]  tile_y;
  } in_item_t;

  typedef struct packed {
    logic               pixel_changed;
    logic               tile_dirty;
    logic [COUNT_W-1:0] dirty_count;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div;
    logic idx;
  } addr_ctl_t;

endpackage

/* hdl/fbdtm_if.sv */
// Valid/ready channel carrying one item.
interface fbdtm_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/framebuffer_dirty_tile_map.sv */
// An item is captured at acceptance, then passes tile divide, index multiply, memory read and
//   read-modify-write before its result enters the output register; a full output register stalls the write-back.
// Each item takes a single read-modify-write pass; a new item is accepted only after the last one writes back.
// Reset (rst_ni low, or a reset-mode item) starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT
//   shadow entries that zeroes the shadow and sets every dirty bit; no item is accepted
//   meanwhile. Config writes are taken at any time.
module framebuffer_dirty_tile_map import fbdtm_pkg::*; #(
  parameter int unsigned TILE_SIZE  = 16,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fbdtm_if.sink                in_ch,
  fbdtm_if.source              out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i
);

  // Tile map geometry; rows are stored at a fixed stride so a size change keeps bits in place.
  localparam int unsigned MAP_COLS    = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned MAP_ROWS    = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned TILE_COUNT  = MAP_COLS * MAP_ROWS;
  localparam int unsigned PIXEL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned TIDX_W      = $clog2(TILE_COUNT > 1 ? TILE_COUNT : 2);
  localparam int unsigned PIDX_W      = $clog2(PIXEL_COUNT);
  localparam logic [31:0] RECIP_M     = 32'(((1 << RECIP_SH) + TILE_SIZE - 1) / TILE_SIZE);

  // Register reset values: 1024 x 1024 frame, clipped to the maximum size.
  localparam int unsigned W_RST    = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int unsigned H_RST    = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;
  localparam int unsigned COLS_RST = (W_RST + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned ROWS_RST = (H_RST + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned CNT_RST  = (COLS_RST * ROWS_RST) % (1 << COUNT_W);

  localparam logic [PIDX_W-1:0] SWEEP_LAST = PIDX_W'(PIXEL_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Configuration: clipped frame size and active tile columns/rows are kept
  // directly, computed at write time.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  used_w_q, used_h_q;
  logic [TCNT_W-1:0] cols_q, rows_q;
  logic              cmp_dis_q;

  logic [DIM_W-1:0]  cfg_w_lim, cfg_h_lim, cfg_lim;
  logic [11:0]       cfg_round;
  logic [31:0]       cfg_prod;
  logic [TCNT_W-1:0] cfg_tiles;

  assign cfg_w_lim = ({2'b00, cfg_wdata_i} > 13'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cfg_wdata_i;
  assign cfg_h_lim = ({2'b00, cfg_wdata_i} > 13'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_wdata_i;
  assign cfg_lim   = (cfg_idx_e'(cfg_idx_i) == CFG_HEIGHT) ? cfg_h_lim : cfg_w_lim;
  // ceil(lim / TILE_SIZE) through the reciprocal
  assign cfg_round = 12'(cfg_lim) + 12'(TILE_SIZE - 1);
  assign cfg_prod  = 32'(cfg_round) * RECIP_M;
  assign cfg_tiles = cfg_prod[RECIP_SH +: TCNT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_w_q  <= DIM_W'(W_RST);
      used_h_q  <= DIM_W'(H_RST);
      cols_q    <= TCNT_W'(COLS_RST);
      rows_q    <= TCNT_W'(ROWS_RST);
      cmp_dis_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH: begin
          used_w_q <= cfg_lim;
          cols_q   <= cfg_tiles;
        end
        CFG_HEIGHT: begin
          used_h_q <= cfg_lim;
          rows_q   <= cfg_tiles;
        end
        CFG_CMP_DIS: begin
          cmp_dis_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [PIDX_W-1:0]  sweep_q, sweep_d;
  logic [COUNT_W-1:0] dirty_count_q, dirty_count_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q;

  logic [MODE_W-1:0]     mode_q;
  logic [PIXEL_BITS-1:0] pv_q;

  logic      in_fire, out_free, commit, go_clear, clearing;
  addr_ctl_t addr_ctl;
  logic      oor;
  logic [TIDX_W-1:0] tidx;
  logic [PIDX_W-1:0] pidx;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // result register is free or drains this cycle
  assign out_free    = !out_valid_q || out_ch.ready;
  assign commit      = (state_q == ST_WR) && out_free;
  assign clearing    = (state_q == ST_CLEAR);

  assign addr_ctl.load = in_fire;
  assign addr_ctl.div  = (state_q == ST_DIV);
  assign addr_ctl.idx  = (state_q == ST_IDX);

  fbdtm_addr #(
    .TILE_SIZE  (TILE_SIZE),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk_i    (clk_i),
    .ctl_i    (addr_ctl),
    .item_i   (in_ch.data),
    .used_w_i (used_w_q),
    .used_h_i (used_h_q),
    .cols_i   (cols_q),
    .rows_i   (rows_q),
    .oor_o    (oor),
    .tidx_o   (tidx),
    .pidx_o   (pidx)
  );

  // ---------------------------------------------------------------------------
  // Memories: shadow frame and dirty bits, registered read.
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] shadow_mem [PIXEL_COUNT];
  logic                  dirty_mem  [TILE_COUNT];
  logic [PIXEL_BITS-1:0] shadow_rd_q;
  logic                  dirty_rd_q;

  logic                  sh_we, sh_wr_en;
  logic [PIDX_W-1:0]     sh_addr;
  logic [PIXEL_BITS-1:0] sh_wdata;
  logic                  dt_we, dt_wbit, dt_wr_en, dt_wdata;
  logic [TIDX_W-1:0]     dt_addr;

  // item result fields
  logic changed, dirty, mark;

  always_comb begin
    sh_we         = 1'b0;
    dt_we         = 1'b0;
    dt_wbit       = 1'b0;
    changed       = 1'b0;
    dirty         = 1'b0;
    mark          = 1'b0;
    go_clear      = 1'b0;
    dirty_count_d = dirty_count_q;
    if (commit && !oor) begin
      case (mode_e'(mode_q))
        MODE_COMPARE: begin
          if (cmp_dis_q) begin
            mark = 1'b1;
          end else if (shadow_rd_q != pv_q) begin
            sh_we   = 1'b1;
            changed = 1'b1;
            mark    = 1'b1;
          end
          dirty = mark || dirty_rd_q;
        end
        MODE_FORCE: begin
          mark  = 1'b1;
          dirty = 1'b1;
        end
        MODE_CLEAN: begin
          if (dirty_rd_q) begin
            dt_we = 1'b1;
            if (dirty_count_q != '0) begin
              dirty_count_d = dirty_count_q - COUNT_W'(1);
            end
          end
        end
        MODE_QUERY: begin
          dirty = dirty_rd_q;
        end
        MODE_RESET: begin
          // count loads with the active tile count, masked to its width
          dirty_count_d = COUNT_W'(20'(cols_q) * 20'(rows_q));
          dirty         = 1'b1;
          go_clear      = 1'b1;
        end
        default: begin
        end
      endcase
      // set a clean tile and count it, saturating
      if (mark && !dirty_rd_q) begin
        dt_we   = 1'b1;
        dt_wbit = 1'b1;
        if (dirty_count_q != COUNT_MAX) begin
          dirty_count_d = dirty_count_q + COUNT_W'(1);
        end
      end
    end
  end

  // Write ports shared between the clearing pass and item write-back.
  assign sh_wr_en = clearing || sh_we;
  assign sh_addr  = clearing ? sweep_q : pidx;
  assign sh_wdata = clearing ? '0 : pv_q;
  assign dt_wr_en = clearing ? (32'(sweep_q) < 32'(TILE_COUNT)) : dt_we;
  assign dt_addr  = clearing ? sweep_q[TIDX_W-1:0] : tidx;
  assign dt_wdata = clearing ? 1'b1 : dt_wbit;

  always_ff @(posedge clk_i) begin
    if (sh_wr_en) begin
      shadow_mem[sh_addr] <= sh_wdata;
    end
    shadow_rd_q <= shadow_mem[pidx];
  end

  always_ff @(posedge clk_i) begin
    if (dt_wr_en) begin
      dirty_mem[dt_addr] <= dt_wdata;
    end
    dirty_rd_q <= dirty_mem[tidx];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + PIDX_W'(1);
        if (sweep_q == SWEEP_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: state_d = ST_IDX;
      ST_IDX: state_d = ST_RD;
      ST_RD:  state_d = ST_WR;
      ST_WR: begin
        if (commit) begin
          state_d = go_clear ? ST_CLEAR : ST_IDLE;
          sweep_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      sweep_q       <= '0;
      dirty_count_q <= COUNT_W'(CNT_RST);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sweep_q       <= sweep_d;
      dirty_count_q <= dirty_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= in_ch.data.mode;
      pv_q   <= in_ch.data.pixel_value[PIXEL_BITS-1:0];
    end
    if (commit) begin
      out_data_q.pixel_changed <= changed;
      out_data_q.tile_dirty    <= dirty;
      out_data_q.dirty_count   <= dirty_count_d;
      out_data_q.out_of_range  <= oor;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_no_commit_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !sh_we && !dt_we)
    else $error("item write-back during clearing pass");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result appeared without a committed item");

  a_clean_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !oor && mode_e'(mode_q) == MODE_CLEAN && dirty_rd_q &&
    dirty_count_q != '0 |=> dirty_count_q == $past(dirty_count_q) - COUNT_W'(1))
    else $error("clean of a dirty tile did not decrement the count");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing && sweep_q == SWEEP_LAST |=> state_q == ST_IDLE)
    else $error("clearing pass did not end at the last entry");

endmodule

/* hdl/fbdtm_addr.sv */
// Address unit: tile divide, range check and memory index generation.
module fbdtm_addr import fbdtm_pkg::*; #(
  parameter int unsigned TILE_SIZE  = 16,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  addr_ctl_t           ctl_i,
  input  in_item_t            item_i,
  input  logic [DIM_W-1:0]    used_w_i,
  input  logic [DIM_W-1:0]    used_h_i,
  input  logic [TCNT_W-1:0]   cols_i,
  input  logic [TCNT_W-1:0]   rows_i,
  output logic                oor_o,
  output logic [$clog2((((MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE) *
                        ((MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE)) > 1 ?
                        (((MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE) *
                        ((MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE)) : 2)-1:0] tidx_o,
  output logic [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0] pidx_o
);

  localparam int unsigned MAP_COLS   = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned MAP_ROWS   = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned TILE_COUNT = MAP_COLS * MAP_ROWS;
  localparam int unsigned TIDX_W     = $clog2(TILE_COUNT > 1 ? TILE_COUNT : 2);
  localparam int unsigned PIDX_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [31:0] RECIP_M    = 32'(((1 << RECIP_SH) + TILE_SIZE - 1) / TILE_SIZE);

  // captured coordinates
  logic [COORD_W-1:0] px_q, py_q;
  logic [TILE_W-1:0]  tx_q, ty_q;
  logic               is_pix_q, is_tile_q;

  // after divide
  logic [TPOS_W-1:0]  col_q, row_q;
  logic               oor_q;

  logic [TIDX_W-1:0]  tidx_q;
  logic [PIDX_W-1:0]  pidx_q;

  logic [31:0]        qx_prod, qy_prod;
  logic [TPOS_W-1:0]  col_d, row_d;
  logic               oor_d;
  logic [31:0]        tidx_full, pidx_full;

  // px / TILE_SIZE via reciprocal; exact for values below 4096
  assign qx_prod = 32'(px_q) * RECIP_M;
  assign qy_prod = 32'(py_q) * RECIP_M;

  always_comb begin
    col_d = '0;
    row_d = '0;
    oor_d = 1'b0;
    if (is_pix_q) begin
      col_d = qx_prod[RECIP_SH +: TPOS_W];
      row_d = qy_prod[RECIP_SH +: TPOS_W];
      oor_d = ({1'b0, px_q} >= used_w_i) || ({1'b0, py_q} >= used_h_i);
    end else if (is_tile_q) begin
      col_d = TPOS_W'(tx_q);
      row_d = TPOS_W'(ty_q);
      oor_d = (TCNT_W'(tx_q) >= cols_i) || (TCNT_W'(ty_q) >= rows_i);
    end
  end

  assign tidx_full = 32'(row_q) * 32'(MAP_COLS) + 32'(col_q);
  assign pidx_full = 32'(py_q) * 32'(MAX_WIDTH) + 32'(px_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      px_q      <= item_i.pixel_x;
      py_q      <= item_i.pixel_y;
      tx_q      <= item_i.tile_x;
      ty_q      <= item_i.tile_y;
      is_pix_q  <= (mode_e'(item_i.mode) == MODE_COMPARE);
      is_tile_q <= (mode_e'(item_i.mode) == MODE_FORCE) ||
                   (mode_e'(item_i.mode) == MODE_CLEAN) ||
                   (mode_e'(item_i.mode) == MODE_QUERY);
    end
    if (ctl_i.div) begin
      col_q <= col_d;
      row_q <= row_d;
      oor_q <= oor_d;
    end
    if (ctl_i.idx) begin
      tidx_q <= tidx_full[TIDX_W-1:0];
      pidx_q <= pidx_full[PIDX_W-1:0];
    end
  end

  assign oor_o  = oor_q;
  assign tidx_o = tidx_q;
  assign pidx_o = pidx_q;

endmodule
